>>> hw/rtl/gscc_pkg.sv
`default_nettype none

package gscc_pkg;

  // Fixed field widths of the input beat
  localparam int unsigned CELLS_W = 64;
  localparam int unsigned DIM_W   = 4;

  // Reachability steps folded into one fill stage
  localparam int unsigned STEPS_PER_STAGE = 8;

endpackage

`default_nettype wire

>>> hw/rtl/grid_single_component_check.sv
// Path: the input beat is registered in occ, then seed, then each fill stage in
// order, then in the result register; the step count sets the fill depth.
// Throughput: one beat per cycle unless a held result stalls the pipe; the fill
// chain is fully pipelined, each fill stage running eight reachability steps.
// Reset: rst_ni clears all stage valid bits asynchronously; data is not reset.
`default_nettype none

module grid_single_component_check #(
  parameter int unsigned GRID_ROWS = 8,
  parameter int unsigned GRID_COLS = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output      logic                         in_ready_o,
  input  wire logic [gscc_pkg::CELLS_W-1:0] cells_i,
  input  wire logic [gscc_pkg::DIM_W-1:0]   height_i,
  input  wire logic [gscc_pkg::DIM_W-1:0]   width_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  output      logic                         single_component_o
);
  import gscc_pkg::*;

  localparam int unsigned N      = GRID_ROWS * GRID_COLS;
  localparam int unsigned NStage = (N + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int unsigned IdxW   = $clog2(CELLS_W);

  // Mask with one column of the fixed layout cleared
  function automatic logic [N-1:0] col_clear_mask(input int unsigned col);
    logic [N-1:0] m;
    m = '1;
    for (int unsigned r = 0; r < GRID_ROWS; r++) begin
      m[r*GRID_COLS + col] = 1'b0;
    end
    return m;
  endfunction

  localparam logic [N-1:0] NotFirstCol = col_clear_mask(0);
  localparam logic [N-1:0] NotLastCol  = col_clear_mask(GRID_COLS - 1);

  // One reachability step: spread to the four neighbours, keep occupied cells
  function automatic logic [N-1:0] grow_step(input logic [N-1:0] reach,
                                             input logic [N-1:0] occ);
    logic [N-1:0] nxt;
    nxt = reach | (reach << GRID_COLS) | (reach >> GRID_COLS)
        | ((reach << 1) & NotFirstCol) | ((reach >> 1) & NotLastCol);
    return nxt & occ;
  endfunction

  logic             adv;
  logic             occ_vld_q;
  logic [N-1:0]     occ_d, occ_q;
  logic             seed_vld_q;
  logic [N-1:0]     seed_occ_q, seed_reach_q;
  logic [NStage-1:0] fill_vld_q;
  logic [N-1:0]     fill_occ_q   [NStage];
  logic [N-1:0]     fill_reach_q [NStage];
  logic [N-1:0]     fill_reach_d [NStage];
  logic             out_vld_q;
  logic             result_q;
  logic [DIM_W-1:0] rows_sat, cols_sat;

  // Whole pipe advances unless a finished result is held
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Saturate the shape and remap cells to a fixed GRID_COLS-wide layout
  always_comb begin
    logic [IdxW-1:0] idx;
    rows_sat = (height_i > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : height_i;
    cols_sat = (width_i  > DIM_W'(GRID_COLS)) ? DIM_W'(GRID_COLS) : width_i;
    occ_d    = '0;
    idx      = '0;
    for (int unsigned r = 0; r < GRID_ROWS; r++) begin
      for (int unsigned c = 0; c < GRID_COLS; c++) begin
        idx = IdxW'(r * cols_sat + c);
        occ_d[r*GRID_COLS + c] = (DIM_W'(r) < rows_sat) && (DIM_W'(c) < cols_sat)
                               && cells_i[idx];
      end
    end
  end

  // Run eight steps per fill stage
  always_comb begin
    logic [N-1:0] occ_s, reach_s;
    for (int unsigned k = 0; k < NStage; k++) begin
      if (k == 0) begin
        occ_s   = seed_occ_q;
        reach_s = seed_reach_q;
      end else begin
        occ_s   = fill_occ_q[k-1];
        reach_s = fill_reach_q[k-1];
      end
      for (int unsigned s = 0; s < STEPS_PER_STAGE; s++) begin
        reach_s = grow_step(reach_s, occ_s);
      end
      fill_reach_d[k] = reach_s;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_vld_q  <= 1'b0;
      seed_vld_q <= 1'b0;
      fill_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else if (adv) begin
      occ_vld_q     <= in_valid_i;
      seed_vld_q    <= occ_vld_q;
      fill_vld_q[0] <= seed_vld_q;
      for (int unsigned k = 1; k < NStage; k++) begin
        fill_vld_q[k] <= fill_vld_q[k-1];
      end
      out_vld_q <= fill_vld_q[NStage-1];
    end
  end

  // Advance payload; seed is the lowest occupied cell
  always_ff @(posedge clk_i) begin
    if (adv) begin
      occ_q           <= occ_d;
      seed_occ_q      <= occ_q;
      seed_reach_q    <= occ_q & (~occ_q + N'(1));
      fill_occ_q[0]   <= seed_occ_q;
      fill_reach_q[0] <= fill_reach_d[0];
      for (int unsigned k = 1; k < NStage; k++) begin
        fill_occ_q[k]   <= fill_occ_q[k-1];
        fill_reach_q[k] <= fill_reach_d[k];
      end
      result_q <= (fill_reach_q[NStage-1] == fill_occ_q[NStage-1]);
    end
  end

  assign out_valid_o        = out_vld_q;
  assign single_component_o = result_q;

endmodule

`default_nettype wire

>>> hw/rtl/gscc_checker.sv
`default_nettype none

module gscc_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [gscc_pkg::CELLS_W-1:0] cells_i,
  input wire logic [gscc_pkg::DIM_W-1:0]   height_i,
  input wire logic [gscc_pkg::DIM_W-1:0]   width_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic                         single_component_o
);

  // Hold a waiting input beat
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cells_i)
      && $stable(height_i) && $stable(width_i))
    else $error("waiting input beat changed");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(single_component_o))
    else $error("stalled result beat changed");

  // Take input whenever the output slot is free or draining
  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output slot");

  // Drop all results once reset has been seen
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat shown after reset");

  // Raise a result beat only when the pipe advanced, never during a stall
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_ready_o))
    else $error("result beat appeared during a stall");

endmodule

bind grid_single_component_check gscc_checker u_gscc_checker (.*);

`default_nettype wire
